// File: hdl/indexed_stack_engine_core_macros.svh
// Assertion macros for the stack engine.
`ifndef INDEXED_STACK_ENGINE_CORE_MACROS_SVH
`define INDEXED_STACK_ENGINE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/ise_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DW     = 32;
  localparam int POS_W  = 7;
  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_PEEP   = 3'd3,
    KIND_CHANGE = 3'd4,
    KIND_DUMP   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOPOS    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ADDR_PUSH = 2'd0,
    ADDR_TOP  = 2'd1,
    ADDR_POS  = 2'd2,
    ADDR_NEXT = 2'd3
  } addr_sel_e;

  typedef struct packed {
    logic      latch;
    logic      mem_wr;
    logic      mem_rd;
    addr_sel_e addr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      idx_load;
    logic      idx_dec;
    logic      res_en;
    logic      res_mem;
    status_e   status;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  full;
    logic  pos_ok;
    logic  idx_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/ise_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ise_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire ise_pkg::dp_sts_t sts_i,
  output ise_pkg::dp_cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ise_pkg::ADDR_TOP;
    cmd_o.status   = ise_pkg::ST_OK;
    state_d        = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (sts_i.kind)
          ise_pkg::KIND_PUSH: begin
            cmd_o.res_en = 1'b1;
            cmd_o.last   = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = ise_pkg::ST_OVERFLOW;
            end else begin
              cmd_o.mem_wr   = 1'b1;
              cmd_o.addr_sel = ise_pkg::ADDR_PUSH;
              cmd_o.cnt_inc  = 1'b1;
            end
          end
          ise_pkg::KIND_POP, ise_pkg::KIND_PEEK: begin
            if (sts_i.empty) begin
              cmd_o.res_en = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = ise_pkg::ST_EMPTY;
            end else begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ise_pkg::ADDR_TOP;
              cmd_o.cnt_dec  = (sts_i.kind == ise_pkg::KIND_POP);
              state_d        = S_READ;
            end
          end
          ise_pkg::KIND_PEEP: begin
            if (!sts_i.pos_ok) begin
              cmd_o.res_en = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = ise_pkg::ST_NOPOS;
            end else begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ise_pkg::ADDR_POS;
              state_d        = S_READ;
            end
          end
          ise_pkg::KIND_CHANGE: begin
            cmd_o.res_en = 1'b1;
            cmd_o.last   = 1'b1;
            if (!sts_i.pos_ok) begin
              cmd_o.status = ise_pkg::ST_NOPOS;
            end else begin
              cmd_o.mem_wr   = 1'b1;
              cmd_o.addr_sel = ise_pkg::ADDR_POS;
            end
          end
          ise_pkg::KIND_DUMP: begin
            if (sts_i.empty) begin
              cmd_o.res_en = 1'b1;
              cmd_o.last   = 1'b1;
              cmd_o.status = ise_pkg::ST_EMPTY;
            end else begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ise_pkg::ADDR_TOP;
              cmd_o.idx_load = 1'b1;
              state_d        = S_DUMP;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.res_en  = 1'b1;
        cmd_o.res_mem = 1'b1;
        cmd_o.last    = 1'b1;
        state_d       = S_IDLE;
      end
      S_DUMP: begin
        cmd_o.res_en  = 1'b1;
        cmd_o.res_mem = 1'b1;
        cmd_o.last    = sts_i.idx_zero;
        if (sts_i.idx_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = ise_pkg::ADDR_NEXT;
          cmd_o.idx_dec  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ise_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ise_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ise_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [ise_pkg::DW-1:0] value_i,
  input  wire logic [ise_pkg::POS_W-1:0]     position_i,
  input  wire ise_pkg::dp_cmd_t              cmd_i,
  output ise_pkg::dp_sts_t                   sts_o,
  output logic signed [ise_pkg::DW-1:0]      data_o,
  output logic [1:0]                         status_o,
  output logic                               last_o,
  output logic                               strobe_o
);

  logic [ise_pkg::DW-1:0]    mem [ise_pkg::DEPTH];
  logic [ise_pkg::DW-1:0]    rd_q;

  ise_pkg::kind_e            kind_q;
  logic [ise_pkg::DW-1:0]    value_q;
  logic [ise_pkg::POS_W-1:0] pos_q;
  logic [ise_pkg::CW-1:0]    count_q, count_d;
  logic [ise_pkg::AW-1:0]    idx_q, idx_d;
  logic [ise_pkg::AW-1:0]    addr;
  logic [ise_pkg::POS_W-1:0] count_ext;

  logic signed [ise_pkg::DW-1:0] data_q;
  ise_pkg::status_e              status_q;
  logic                          last_q;
  logic                          strobe_q;

  assign count_ext = ise_pkg::POS_W'(count_q);

  always_comb begin
    case (cmd_i.addr_sel)
      ise_pkg::ADDR_PUSH: addr = ise_pkg::AW'(count_q);
      ise_pkg::ADDR_TOP:  addr = ise_pkg::AW'(count_q - ise_pkg::CW'(1));
      ise_pkg::ADDR_POS:  addr = ise_pkg::AW'(count_ext - pos_q);
      ise_pkg::ADDR_NEXT: addr = idx_q - ise_pkg::AW'(1);
      default:            addr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= value_q;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= ise_pkg::kind_e'(kind_i);
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (cmd_i.res_en) begin
      data_q   <= cmd_i.res_mem ? $signed(rd_q) : '0;
      status_q <= cmd_i.status;
      last_q   <= cmd_i.last;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + ise_pkg::CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - ise_pkg::CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_load) begin
      idx_d = ise_pkg::AW'(count_q - ise_pkg::CW'(1));
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - ise_pkg::AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      strobe_q <= cmd_i.res_en;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == ise_pkg::CW'(ise_pkg::DEPTH));
  assign sts_o.pos_ok   = (pos_q != '0) && (pos_q <= count_ext);
  assign sts_o.idx_zero = (idx_q == '0);

  assign data_o   = data_q;
  assign status_o = status_q;
  assign last_o   = last_q;
  assign strobe_o = strobe_q;

endmodule

`default_nettype wire

// File: hdl/indexed_stack_engine_core.sv
// Push and change: accepted, result registered from the execute state; next start taken once idle.
// Pop, peek and peep: one registered memory read, then the result is registered in the read state.
// Dump: count results on consecutive cycles, the first registered in the dump state.
// Errors and ignored kinds finish in the execute state. One item at a time; busy_o shows it.
// Results cannot be stalled. Reset (rst_ni low, async) empties the stack.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_stack_engine_core_macros.svh"

module indexed_stack_engine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ise_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [ise_pkg::DW-1:0] value_i,
  input  wire logic [ise_pkg::POS_W-1:0]     position_i,
  output logic                               strobe_o,
  output logic signed [ise_pkg::DW-1:0]      data_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);

  ise_pkg::dp_cmd_t cmd;
  ise_pkg::dp_sts_t sts;

  ise_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  ise_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .position_i (position_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .data_o     (data_o),
    .status_o   (status_o),
    .last_o     (last_o),
    .strobe_o   (strobe_o)
  );

  `ISE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, strobe_o && (status_o != ise_pkg::ST_OK), data_o == '0)
  `ISE_ASSERT_NXT(a_take_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ISE_ASSERT_NXT(a_dump_run, clk_i, rst_ni, strobe_o && !last_o, strobe_o)
  `ISE_ASSERT_IMP(a_nolast_ok, clk_i, rst_ni, strobe_o && !last_o, status_o == ise_pkg::ST_OK)

endmodule

`default_nettype wire

// File: test/indexed_stack_engine_core_checker.sv
`timescale 1ns / 1ps

module indexed_stack_engine_core_checker
  import ise_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic signed [DW-1:0]    value_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic                    strobe_i,
  input  logic signed [DW-1:0]    data_i,
  input  logic [1:0]              status_i,
  input  logic                    last_i,
  output int                      fail_count_o,
  output int                      owed_count_o
);

  typedef struct packed {
    logic signed [DW-1:0] data;
    status_e              status;
    logic                 last;
  } stack_result_t;

  stack_result_t owed_q[$];
  logic [DW-1:0] stack_words [DEPTH];
  int            stack_depth;

  initial begin
    fail_count_o = 0;
    owed_count_o = 0;
    stack_depth  = 0;
  end

  function automatic void owe(logic [DW-1:0] data, status_e status, logic last);
    stack_result_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    owed_q.push_back(r);
  endfunction

  function automatic void apply_item(logic [KIND_W-1:0] kind, logic [DW-1:0] value,
                                     logic [POS_W-1:0] pos);
    int p;
    p = int'(pos);
    case (kind)
      KIND_PUSH: begin
        if (stack_depth >= DEPTH) begin
          owe('0, ST_OVERFLOW, 1'b1);
        end else begin
          stack_words[stack_depth] = value;
          stack_depth++;
          owe('0, ST_OK, 1'b1);
        end
      end
      KIND_POP: begin
        if (stack_depth == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          stack_depth--;
          owe(stack_words[stack_depth], ST_OK, 1'b1);
        end
      end
      KIND_PEEK: begin
        if (stack_depth == 0) owe('0, ST_EMPTY, 1'b1);
        else owe(stack_words[stack_depth-1], ST_OK, 1'b1);
      end
      KIND_PEEP: begin
        if (p < 1 || p > stack_depth) owe('0, ST_NOPOS, 1'b1);
        else owe(stack_words[stack_depth-p], ST_OK, 1'b1);
      end
      KIND_CHANGE: begin
        if (p < 1 || p > stack_depth) begin
          owe('0, ST_NOPOS, 1'b1);
        end else begin
          stack_words[stack_depth-p] = value;
          owe('0, ST_OK, 1'b1);
        end
      end
      KIND_DUMP: begin
        if (stack_depth == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < stack_depth; i++)
            owe(stack_words[stack_depth-1-i], ST_OK, i == stack_depth - 1);
        end
      end
      default: ;  // unused kinds: no result, no state change
    endcase
  endfunction

  always @(posedge clk_i) begin
    stack_result_t want;
    if (!rst_ni) begin
      stack_depth = 0;
      owed_q.delete();
    end else begin
      if (strobe_i === 1'b1) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result data %0d status %0d last %0b",
                   $time, data_i, status_i, last_i);
          fail_count_o++;
        end else begin
          want = owed_q.pop_front();
          if (data_i !== want.data || status_i !== want.status || last_i !== want.last) begin
            $display("%0t: expected data %0d status %0d last %0b, got data %0d status %0d last %0b",
                     $time, want.data, want.status, want.last, data_i, status_i, last_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) apply_item(kind_i, value_i, position_i);
    end
    owed_count_o = owed_q.size();
  end

endmodule

// File: test/indexed_stack_engine_core_tb.sv
`timescale 1ns / 1ps

module indexed_stack_engine_core_tb;
  import ise_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN} fill_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [KIND_W-1:0]        kind_i;
  logic signed [DW-1:0]     value_i;
  logic [POS_W-1:0]         position_i;
  logic                     strobe_o;
  logic signed [DW-1:0]     data_o;
  logic [1:0]               status_o;
  logic                     last_o;

  int fail_count;
  int owed_count;
  int cycle_count;
  int shadow_depth;
  int calm_left;

  indexed_stack_engine_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .position_i (position_i),
    .strobe_o   (strobe_o),
    .data_o     (data_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  indexed_stack_engine_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .strobe_i     (strobe_o),
    .data_i       (data_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .owed_count_o (owed_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("indexed_stack_engine_core_tb NOT OK");
      $finish;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one, with calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) calm_left = $urandom_range(20, 8);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return POS_W'((shadow_depth < DEPTH) ? shadow_depth + 1 : DEPTH);
    if (r == 2 || shadow_depth == 0) return POS_W'($urandom_range(DEPTH));
    return POS_W'($urandom_range(shadow_depth, 1));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(fill_mode_e mode);
    int r;
    int w_push, w_pop;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  begin w_push = 80; w_pop = 84; end
      MODE_DRAIN: begin w_push = 10; w_pop = 70; end
      default:    begin w_push = 35; w_pop = 55; end
    endcase
    if (r < w_push) return KIND_PUSH;
    if (r < w_pop)  return KIND_POP;
    r = $urandom_range(99);
    if (r < 22) return KIND_PEEK;
    if (r < 50) return KIND_PEEP;
    if (r < 78) return KIND_CHANGE;
    if (r < 92) return KIND_DUMP;
    return (r < 96) ? KIND_SPARE_6 : KIND_SPARE_7;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic transfer(input logic [KIND_W-1:0] kind, input logic [DW-1:0] value,
                          input logic [POS_W-1:0] pos, input int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i    = 1'b1;
    kind_i     = kind;
    value_i    = value;
    position_i = pos;
    do @(posedge clk_i); while (busy_o);
    case (kind)
      KIND_PUSH: if (shadow_depth < DEPTH) shadow_depth++;
      KIND_POP:  if (shadow_depth > 0) shadow_depth--;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i = 1'b0;
    while (owed_count != 0) @(negedge clk_i);
  endtask

  initial begin
    fill_mode_e        mode;
    int                done;
    logic [KIND_W-1:0] kind;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = '0;
    value_i      = '0;
    position_i   = '0;
    cycle_count  = 0;
    shadow_depth = 0;
    calm_left    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty stack errors, then edge-value pushes, position checks, dumps and spare kinds
    transfer(KIND_POP,     32'h1234_5678, 7'd0,  pick_gap());
    transfer(KIND_PEEK,    32'h0,         7'd0,  pick_gap());
    transfer(KIND_DUMP,    32'h0,         7'd0,  pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd1,  pick_gap());
    transfer(KIND_CHANGE,  32'h5555_5555, 7'd1,  pick_gap());
    transfer(KIND_SPARE_6, 32'hffff_ffff, 7'd127, pick_gap());
    transfer(KIND_PUSH,    32'h7fff_ffff, 7'd0,  pick_gap());
    transfer(KIND_PUSH,    32'h8000_0000, 7'd0,  pick_gap());
    transfer(KIND_PUSH,    32'h0000_0000, 7'd0,  pick_gap());
    transfer(KIND_PUSH,    32'hffff_ffff, 7'd0,  pick_gap());
    transfer(KIND_PEEK,    32'h0,         7'd0,  pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd1,  pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd4,  pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd0,  pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd5,  pick_gap());
    transfer(KIND_CHANGE,  32'h5a5a_a5a5, 7'd4,  pick_gap());
    transfer(KIND_CHANGE,  32'h1111_1111, 7'd0,  pick_gap());
    transfer(KIND_CHANGE,  32'h2222_2222, 7'd64, pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd4,  pick_gap());
    transfer(KIND_DUMP,    32'h0,         7'd0,  pick_gap());
    transfer(KIND_POP,     32'h0,         7'd0,  pick_gap());
    transfer(KIND_SPARE_7, 32'ha5a5_5a5a, 7'd64, pick_gap());
    transfer(KIND_DUMP,    32'h0,         7'd0,  pick_gap());
    transfer(KIND_PEEP,    32'h0,         7'd3,  pick_gap());
    drain_results();

    mode = MODE_MIX;
    done = 0;
    while (done < 160) begin
      if (mode == MODE_MIX && done == 30) mode = MODE_FILL;
      if (mode == MODE_DRAIN && shadow_depth == 0) mode = MODE_MIX;
      if (mode == MODE_FILL && shadow_depth == DEPTH) begin
        // full stack: overflow, deepest entry, full dump
        repeat (3) transfer(KIND_PUSH, pick_value(), pick_pos(), pick_gap());
        transfer(KIND_PEEP,   pick_value(), POS_W'(DEPTH), pick_gap());
        transfer(KIND_CHANGE, pick_value(), POS_W'(DEPTH), pick_gap());
        transfer(KIND_PEEP,   pick_value(), POS_W'(DEPTH), pick_gap());
        transfer(KIND_DUMP,   pick_value(), pick_pos(),    pick_gap());
        done += 7;
        drain_results();
        mode = MODE_DRAIN;
      end else begin
        kind = pick_kind(mode);
        transfer(kind, pick_value(), pick_pos(), pick_gap());
        if (kind != KIND_SPARE_6 && kind != KIND_SPARE_7) done++;
      end
    end

    drain_results();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && owed_count == 0) begin
      $display("indexed_stack_engine_core_tb OK");
    end else begin
      $display("indexed_stack_engine_core_tb NOT OK");
    end
    $finish;
  end

endmodule
